/* rtl/core/rhsi_pkg.sv */
// rgb to hsi conversion: shared types, constants and the cordic angle table
package rhsi_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STEPS    = 8;
  localparam int XW           = 28;   // cordic vector width, signed
  localparam int AW           = 26;   // angle accumulator width, signed
  localparam int NUMW         = 18;   // saturation numerator width
  localparam int SUMW         = 10;   // width of b+g+r
  localparam int SQRT3_Q16    = 113512;
  localparam int INV3_MUL     = 683;  // floor(sum*683 >> 11) == sum/3 for sum <= 765
  localparam int INV3_SHIFT   = 11;
  localparam logic signed [AW-1:0] QUARTER_TURN = AW'(4194304);
  localparam logic signed [AW-1:0] HALF_TURN    = AW'(8388608);
  localparam logic [24:0]          FULL_TURN    = 25'd16777216;
  localparam logic [7:0]           HUE_HALF     = 8'd127;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] intensity;
  } hsi_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] ang;
    logic [NUMW-1:0]      rem;
    logic [SUMW-1:0]      den;
    logic [7:0]           quo;
    logic [7:0]           inten;
    logic                 gray;
    logic                 gb_equal;
    logic                 x_pos;
    logic                 b_gt_g;
  } stage_t;

  // round(atan(2^-i) * 2^24 / 2pi)
  function automatic logic signed [AW-1:0] atan_unit(input int i);
    logic signed [AW-1:0] v;
    case (i)
      0:       v = AW'(2097152);
      1:       v = AW'(1238021);
      2:       v = AW'(654136);
      3:       v = AW'(332050);
      4:       v = AW'(166669);
      5:       v = AW'(83416);
      6:       v = AW'(41718);
      7:       v = AW'(20860);
      8:       v = AW'(10430);
      9:       v = AW'(5215);
      10:      v = AW'(2608);
      11:      v = AW'(1304);
      12:      v = AW'(652);
      13:      v = AW'(326);
      14:      v = AW'(163);
      default: v = AW'(81);
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/rhsi_front.sv */
// front end: pixel analysis, vector setup, saturation numerator, intensity
module rhsi_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            vld_in,
  input  rhsi_pkg::pixel_t pix,
  output logic            vld_out,
  output rhsi_pkg::stage_t st_out
);
  import rhsi_pkg::*;

  logic                   a_vld;
  logic [SUMW-1:0]        a_sum;
  logic [7:0]             a_mn;
  logic signed [10:0]     a_xi;
  logic [7:0]             a_d;
  logic                   a_gray;
  logic                   a_gb;
  logic                   a_bgt;

  logic [SUMW-1:0]        sum_c;
  logic [7:0]             mn_c;
  logic signed [10:0]     xi_c;

  always_comb begin
    sum_c = SUMW'(pix.blue) + SUMW'(pix.green) + SUMW'(pix.red);
    mn_c  = pix.blue;
    if (pix.green < mn_c) mn_c = pix.green;
    if (pix.red < mn_c) mn_c = pix.red;
    xi_c  = $signed({2'b00, pix.red, 1'b0}) - $signed({3'b000, pix.green})
            - $signed({3'b000, pix.blue});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= vld_in;
    end
    a_sum  <= sum_c;
    a_mn   <= mn_c;
    a_xi   <= xi_c;
    a_d    <= (pix.green > pix.blue) ? pix.green - pix.blue : pix.blue - pix.green;
    a_gray <= (pix.red == pix.green) && (pix.green == pix.blue);
    a_gb   <= (pix.green == pix.blue);
    a_bgt  <= (pix.blue > pix.green);
  end

  logic [24:0]             y_mult;
  logic signed [XW-1:0]    x_in;
  logic signed [XW-1:0]    y_in;
  logic [SUMW-1:0]         diff;
  logic [19:0]             inv_prod;
  stage_t                  st_next;

  always_comb begin
    y_mult   = 25'(a_d) * 25'(SQRT3_Q16);
    x_in     = $signed({{(XW-27){a_xi[10]}}, a_xi, 16'b0});
    y_in     = $signed({{(XW-25){1'b0}}, y_mult});
    diff     = a_sum - (SUMW'({a_mn, 1'b0}) + SUMW'(a_mn));
    inv_prod = 20'(a_sum) * 20'(INV3_MUL);

    st_next          = '0;
    // left half plane: turn by -90 degrees first
    if (a_xi < 0) begin
      st_next.x   = y_in;
      st_next.y   = -x_in;
      st_next.ang = QUARTER_TURN;
    end else begin
      st_next.x   = x_in;
      st_next.y   = y_in;
      st_next.ang = '0;
    end
    st_next.rem      = {diff, 8'b0} - NUMW'(diff);
    st_next.den      = a_sum;
    st_next.quo      = '0;
    st_next.inten    = inv_prod[INV3_SHIFT+7:INV3_SHIFT];
    st_next.gray     = a_gray;
    st_next.gb_equal = a_gb;
    st_next.x_pos    = (a_xi > 0);
    st_next.b_gt_g   = a_bgt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= a_vld;
    end
    st_out <= st_next;
  end

endmodule

/* rtl/core/rhsi_stage.sv */
// one pipeline stage: one cordic vectoring step, and one quotient bit in the first DIV_STEPS stages
module rhsi_stage #(
  parameter int STEP = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             vld_in,
  input  rhsi_pkg::stage_t st_in,
  output logic             vld_out,
  output rhsi_pkg::stage_t st_out
);
  import rhsi_pkg::*;

  stage_t               cor;
  stage_t               st_next;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  always_comb begin
    cor = st_in;
    dx  = st_in.y >>> STEP;
    dy  = st_in.x >>> STEP;
    if (st_in.y > 0) begin
      cor.x   = st_in.x + dx;
      cor.y   = st_in.y - dy;
      cor.ang = st_in.ang + atan_unit(STEP);
    end else begin
      cor.x   = st_in.x - dx;
      cor.y   = st_in.y + dy;
      cor.ang = st_in.ang - atan_unit(STEP);
    end
  end

  generate
    if (STEP < DIV_STEPS) begin : g_div
      localparam int QB = DIV_STEPS - 1 - STEP;
      logic [NUMW-1:0] trial;
      always_comb begin
        st_next = cor;
        trial   = NUMW'(st_in.den) << QB;
        if (st_in.rem >= trial) begin
          st_next.rem     = st_in.rem - trial;
          st_next.quo[QB] = 1'b1;
        end
      end
    end else begin : g_nodiv
      always_comb begin
        st_next = cor;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
    st_out <= st_next;
  end

endmodule

/* rtl/core/rhsi_back.sv */
// back end: angle clamp, hue scaling, special cases, result register
module rhsi_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             vld_in,
  input  rhsi_pkg::stage_t st_in,
  output logic             vld_out,
  output rhsi_pkg::hsi_t   res
);
  import rhsi_pkg::*;

  logic [23:0] angc;
  logic [24:0] v;
  logic [32:0] prod;
  hsi_t        res_next;

  always_comb begin
    if (st_in.ang < 0) begin
      angc = '0;
    end else if (st_in.ang > HALF_TURN) begin
      angc = 24'(HALF_TURN);
    end else begin
      angc = st_in.ang[23:0];
    end
    v    = st_in.b_gt_g ? FULL_TURN - 25'(angc) : 25'(angc);
    prod = {v, 8'b0} - 33'(v);   // 255 * v

    if (st_in.gray) begin
      res_next.hue = '0;
    end else if (st_in.gb_equal) begin
      res_next.hue = st_in.x_pos ? 8'd0 : HUE_HALF;
    end else begin
      res_next.hue = prod[31:24];
    end
    // black pixel: divider sees 0/0
    res_next.saturation = (st_in.den == '0) ? 8'd0 : st_in.quo;
    res_next.intensity  = st_in.inten;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
    res <= res_next;
  end

endmodule

/* rtl/core/rgb_to_hsi_pixel_top.sv */
// rgb to hsi pixel converter, top level
//
//  channel   ports            direction  handshake
//  pixel     start, pixel     in         start & !busy
//  result    done, result     out        done, one cycle, no back pressure
//
// one word enters every clock; busy is always low
// result shows with done, registered through these stages in order:
// 2 front stages, 16 cordic stages (first 8 also make one quotient bit each),
// 1 output stage
// synchronous reset clears the valid bits only

module rgb_to_hsi_pixel_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rhsi_pkg::pixel_t pixel,
  output logic             done,
  output rhsi_pkg::hsi_t   result
);
  import rhsi_pkg::*;

  logic   vld [CORDIC_STEPS+1];
  stage_t st  [CORDIC_STEPS+1];

  assign busy = 1'b0;

  rhsi_front u_front (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (start),
    .pix     (pixel),
    .vld_out (vld[0]),
    .st_out  (st[0])
  );

  generate
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
      rhsi_stage #(
        .STEP (i)
      ) u_stage (
        .clk     (clk),
        .rst     (rst),
        .vld_in  (vld[i]),
        .st_in   (st[i]),
        .vld_out (vld[i+1]),
        .st_out  (st[i+1])
      );
    end
  endgenerate

  rhsi_back u_back (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (vld[CORDIC_STEPS]),
    .st_in   (st[CORDIC_STEPS]),
    .vld_out (done),
    .res     (result)
  );

endmodule

/* bench/rgb_to_hsi_pixel_checker.sv */
// checker for the rgb to hsi converter: predicts each hsi word and compares
module rgb_to_hsi_pixel_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  rhsi_pkg::pixel_t pixel,
  input  logic             done,
  input  rhsi_pkg::hsi_t   result,
  output int               fail_count,
  output int               pending
);
  import rhsi_pkg::*;

  localparam longint ATAN_TBL [16] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81};

  hsi_t hsi_queue[$];

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  // cordic vectoring angle, full turn = 2^24, clamped to half a turn
  function automatic longint hue_angle(longint x, longint y);
    longint ang, t, dx, dy;
    ang = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      ang = 4194304;
    end
    for (int i = 0; i < 16; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        ang += ATAN_TBL[i];
      end else begin
        x -= dx;
        y += dy;
        ang -= ATAN_TBL[i];
      end
    end
    if (ang < 0) ang = 0;
    if (ang > 8388608) ang = 8388608;
    return ang;
  endfunction

  function automatic hsi_t convert_pixel(pixel_t p);
    hsi_t   h;
    longint b, g, r, sum, mn, xi, d, ang, hv;
    b = p.blue;
    g = p.green;
    r = p.red;
    sum = b + g + r;
    mn = b;
    if (g < mn) mn = g;
    if (r < mn) mn = r;
    xi = 2 * r - g - b;
    if (r == g && g == b) hv = 0;
    else if (g == b) hv = (xi > 0) ? 0 : 127;
    else begin
      d = (g > b) ? g - b : b - g;
      ang = hue_angle(xi * 65536, d * 113512);
      if (b <= g) hv = (255 * ang) >>> 24;
      else hv = (255 * (16777216 - ang)) >>> 24;
    end
    h.hue = hv[7:0];
    h.saturation = (sum == 0) ? 8'd0 : 8'((255 * (sum - 3 * mn)) / sum);
    h.intensity = 8'(sum / 3);
    return h;
  endfunction

  assign pending = hsi_queue.size();

  always @(posedge clk) begin
    hsi_t want;
    if (rst) begin
      fail_count <= 0;
      hsi_queue.delete();
    end else begin
      if (start && !busy) hsi_queue.push_back(convert_pixel(pixel));
      if (done) begin
        if (hsi_queue.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = hsi_queue.pop_front();
          if (result != want) begin
            if (result.hue != want.hue)
              $error("hue expected %0d got %0d", want.hue, result.hue);
            if (result.saturation != want.saturation)
              $error("saturation expected %0d got %0d", want.saturation, result.saturation);
            if (result.intensity != want.intensity)
              $error("intensity expected %0d got %0d", want.intensity, result.intensity);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* bench/tb_rgb_to_hsi_pixel_top.sv */
// testbench top for the rgb to hsi converter: stimulus and verdict
module tb_rgb_to_hsi_pixel_top;
  import rhsi_pkg::*;

  localparam int LATENCY = 19;
  localparam int STALL_LIMIT = 2000;

  logic   clk, rst, start, busy, done;
  pixel_t pixel;
  hsi_t   result;
  int     fail_count, pending, idle_cycles;

  rgb_to_hsi_pixel_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel(pixel), .done(done), .result(result)
  );

  rgb_to_hsi_pixel_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_rgb_to_hsi_pixel_top: errors");
      $finish;
    end
  end

  // hold one word until accepted, after a random gap; gap 0 keeps start high
  task automatic send_word(pixel_t p, bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_rgb(int b, int g, int r, bit allow_gap);
    pixel_t p;
    p.blue = b[7:0];
    p.green = g[7:0];
    p.red = r[7:0];
    send_word(p, allow_gap);
  endtask

  initial begin
    pixel_t p;
    int v, run_gaps;
    rst = 1;
    start = 0;
    pixel = '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // gray, black, white, green equals blue on both sides, primaries
    send_rgb(0, 0, 0, 0);
    send_rgb(255, 255, 255, 0);
    send_rgb(128, 128, 128, 0);
    send_rgb(10, 10, 200, 0);
    send_rgb(200, 200, 10, 0);
    send_rgb(0, 0, 255, 0);
    send_rgb(255, 255, 0, 0);
    send_rgb(0, 255, 0, 1);
    send_rgb(255, 0, 0, 1);
    send_rgb(0, 255, 255, 1);
    send_rgb(255, 0, 255, 1);
    send_rgb(0, 1, 0, 1);
    send_rgb(1, 0, 0, 1);
    send_rgb(1, 0, 255, 1);
    send_rgb(0, 1, 255, 1);
    send_rgb(254, 255, 0, 1);
    send_rgb(255, 254, 0, 1);
    send_rgb(85, 170, 255, 1);
    send_rgb(170, 85, 255, 1);
    send_rgb(1, 2, 3, 1);

    // sender holds off until the pipeline has drained
    start <= 1'b0;
    while (pending != 0) @(posedge clk);

    run_gaps = 1;
    for (int i = 0; i < 2000; i++) begin
      if (i % 250 == 0) run_gaps = $urandom_range(0, 1);
      v = $urandom_range(0, 9);
      p = pixel_t'(24'($urandom));
      if (v == 0) p.green = p.blue;
      else if (v == 1) begin
        p.green = p.blue;
        p.red = p.blue;
      end else if (v == 2) begin
        p.green = p.blue + 8'($urandom_range(0, 2)) - 8'd1;
      end
      send_word(p, run_gaps && $urandom_range(0, 1));
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0) $display("tb_rgb_to_hsi_pixel_top: clean");
    else $display("tb_rgb_to_hsi_pixel_top: errors");
    $finish;
  end
endmodule
